/* design/slar_pkg.sv */
// Package for the ordered list block: depth, widths, request and status codes,
// and the command word broadcast to the storage cells.
// Depends on nothing.
package slar_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int DATA_W     = 32;

    typedef enum logic [1:0] {
        REQ_APPEND      = 2'd0,
        REQ_REMOVE_HEAD = 2'd1,
        REQ_REMOVE_TAIL = 2'd2,
        REQ_REMOVE_POS  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // Command word from the controller to every cell in the row
    typedef struct packed {
        logic               wr;     // write the append word at idx
        logic               shift;  // cells at idx and above take their neighbor's word
        logic [IDX_W-1:0]   idx;
        logic [DATA_W-1:0]  wdata;
    } cell_cmd_t;

endpackage

/* design/slar_cell.sv */
// One storage cell of the list row: holds one entry and either loads the
// append word or takes the word of its upper neighbor. Depends on slar_pkg.
module slar_cell (
    input  logic                         clk,
    input  slar_pkg::cell_cmd_t          cmd,
    input  logic [slar_pkg::IDX_W-1:0]   cell_idx,
    input  logic [slar_pkg::DATA_W-1:0]  neighbor_data,
    output logic [slar_pkg::DATA_W-1:0]  data,
    output logic [slar_pkg::DATA_W-1:0]  sel_data
);

    logic [slar_pkg::DATA_W-1:0] data_reg;
    logic [slar_pkg::DATA_W-1:0] data_next;
    logic                        hit;

    assign hit = (cell_idx == cmd.idx);

    // Load on append, advance from the neighbor on a remove at or below us
    always_comb
    begin
        data_next = data_reg;
        if (cmd.wr && hit)
        begin
            data_next = cmd.wdata;
        end
        else if (cmd.shift && (cell_idx >= cmd.idx))
        begin
            data_next = neighbor_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    // Drive our word onto the gather tree only when addressed
    assign sel_data = hit ? data_reg : '0;

endmodule

/* design/slar_ctrl.sv */
// Controller of the ordered list: handshake, entry count, request decode,
// status and the output word register. Depends on slar_pkg.
module slar_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   req_type,
    input  logic [slar_pkg::DATA_W-1:0]  value,
    input  logic [4:0]                   position,
    output slar_pkg::cell_cmd_t          cmd,
    input  logic [slar_pkg::DATA_W-1:0]  taken_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [slar_pkg::DATA_W-1:0]  removed_value,
    output logic [1:0]                   status,
    output logic [4:0]                   entry_count
);

    logic                          accept;
    logic [slar_pkg::CNT_W-1:0]    count_reg;
    logic [slar_pkg::CNT_W-1:0]    count_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [slar_pkg::DATA_W-1:0]   removed_reg;
    logic [slar_pkg::DATA_W-1:0]   removed_next;
    slar_pkg::status_t             status_reg;
    slar_pkg::status_t             status_next;
    slar_pkg::status_t             st;
    logic                          full;
    logic                          empty;
    logic                          pos_bad;
    logic                          do_wr;
    logic                          do_shift;
    logic [slar_pkg::IDX_W-1:0]    idx;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign full    = (count_reg >= slar_pkg::CNT_W'(slar_pkg::LIST_DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_bad = (position == 5'd0) || (32'(position) > 32'(count_reg));

    // Decode the request into a cell command and a status
    always_comb
    begin
        st       = slar_pkg::ST_OK;
        do_wr    = 1'b0;
        do_shift = 1'b0;
        idx      = '0;
        unique case (slar_pkg::req_t'(req_type))
            slar_pkg::REQ_APPEND:
            begin
                idx = slar_pkg::IDX_W'(count_reg);
                if (full)
                    st = slar_pkg::ST_FULL;
                else
                    do_wr = 1'b1;
            end
            slar_pkg::REQ_REMOVE_HEAD:
            begin
                idx = '0;
                if (empty)
                    st = slar_pkg::ST_EMPTY;
                else
                    do_shift = 1'b1;
            end
            slar_pkg::REQ_REMOVE_TAIL:
            begin
                idx = slar_pkg::IDX_W'(count_reg - 1'b1);
                if (empty)
                    st = slar_pkg::ST_EMPTY;
                else
                    do_shift = 1'b1;
            end
            slar_pkg::REQ_REMOVE_POS:
            begin
                idx = slar_pkg::IDX_W'(position - 5'd1);
                if (empty)
                    st = slar_pkg::ST_EMPTY;
                else if (pos_bad)
                    st = slar_pkg::ST_BADPOS;
                else
                    do_shift = 1'b1;
            end
            default:
            begin
                st = slar_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        cmd.wr    = accept && do_wr;
        cmd.shift = accept && do_shift;
        cmd.idx   = idx;
        cmd.wdata = value;
    end

    // Next count and output word
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = st;
            removed_next   = do_shift ? taken_data : '0;
            if (do_wr)
                count_next = count_reg + 1'b1;
            else if (do_shift)
                count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        removed_reg <= removed_next;
        status_reg  <= status_next;
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign entry_count   = 5'(count_reg);

    // Count stays within the list depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= slar_pkg::CNT_W'(slar_pkg::LIST_DEPTH))
        else $error("entry count beyond list depth");

    // An accepted append to a non-full list grows the count by one
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req_type == slar_pkg::REQ_APPEND) && !full
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("append did not grow count");

    // A refused word carries a zero removed value
    a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != slar_pkg::ST_OK) |-> removed_reg == '0)
        else $error("refused request carries a removed value");

    // Full status only ever reported with a full list
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (st == slar_pkg::ST_FULL) |->
        count_reg == slar_pkg::CNT_W'(slar_pkg::LIST_DEPTH))
        else $error("full status on a list that is not full");

endmodule

/* design/sequence_list_append_remove_top.sv */
// Each request's result is registered and shows in the cycle after acceptance.
// Throughput: one request per cycle while results are taken; the cell row shifts
// to close a gap in that same cycle, and the output register lets the next word
// in as the current result is taken. Reset clears the entry count and the output
// valid; entry contents are not reset and are only read below the count.
module sequence_list_append_remove_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   req_type,
    input  logic signed [31:0]           value,
    input  logic [4:0]                   position,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [31:0]           removed_value,
    output logic [1:0]                   status,
    output logic [4:0]                   entry_count
);

    slar_pkg::cell_cmd_t          cmd;
    logic [slar_pkg::DATA_W-1:0]  cell_data [slar_pkg::LIST_DEPTH];
    logic [slar_pkg::DATA_W-1:0]  cell_sel  [slar_pkg::LIST_DEPTH];
    logic [slar_pkg::DATA_W-1:0]  taken_data;
    logic [slar_pkg::DATA_W-1:0]  removed_raw;

    slar_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .value         (value),
        .position      (position),
        .cmd           (cmd),
        .taken_data    (taken_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .removed_value (removed_raw),
        .status        (status),
        .entry_count   (entry_count)
    );

    assign removed_value = removed_raw;

    // Row of cells, each fed by its upper neighbor
    for (genvar i = 0; i < slar_pkg::LIST_DEPTH; i++)
    begin : g_cell
        logic [slar_pkg::DATA_W-1:0] up_data;
        if (i == slar_pkg::LIST_DEPTH - 1)
        begin : g_last
            assign up_data = '0;
        end
        else
        begin : g_mid
            assign up_data = cell_data[i + 1];
        end

        slar_cell u_cell (
            .clk           (clk),
            .cmd           (cmd),
            .cell_idx      (slar_pkg::IDX_W'(i)),
            .neighbor_data (up_data),
            .data          (cell_data[i]),
            .sel_data      (cell_sel[i])
        );
    end

    // Gather the addressed cell's word
    always_comb
    begin
        taken_data = '0;
        for (int i = 0; i < slar_pkg::LIST_DEPTH; i++)
        begin
            taken_data = taken_data | cell_sel[i];
        end
    end

endmodule

/* tb/sv/tb_sequence_list_append_remove_top.sv */
// Testbench for the bounded ordered list: directed and random request words,
// checked one by one against a queue-based list predictor.
// Depends on slar_pkg and sequence_list_append_remove_top.
`timescale 1ns / 1ps

module tb_sequence_list_append_remove_top;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [31:0] removed;
        slar_pkg::status_t  status;
        logic [4:0]         count;
    } list_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         req_type = 2'd0;
    logic signed [31:0] value = 32'sd0;
    logic [4:0]         position = 5'd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] removed_value;
    logic [1:0]         status;
    logic [4:0]         entry_count;

    // Predicted list contents and the results still owed by the block
    logic signed [31:0] list_model[$];
    list_result_t       expected_results[$];

    int  err_count = 0;
    int  cycle_count = 0;
    int  rx_hold_cycles = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;

    sequence_list_append_remove_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .value         (value),
        .position      (position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .removed_value (removed_value),
        .status        (status),
        .entry_count   (entry_count)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Apply one request to the predicted list and return what the block owes
    function automatic list_result_t apply_request(input slar_pkg::req_t req,
                                                   input logic signed [31:0] val,
                                                   input logic [4:0] pos);
        list_result_t res;
        res.removed = 32'sd0;
        res.status  = slar_pkg::ST_OK;
        if (req == slar_pkg::REQ_APPEND)
        begin
            if (list_model.size() >= slar_pkg::LIST_DEPTH)
                res.status = slar_pkg::ST_FULL;
            else
                list_model.push_back(val);
        end
        else if (list_model.size() == 0)
        begin
            // empty check wins over the position check
            res.status = slar_pkg::ST_EMPTY;
        end
        else if (req == slar_pkg::REQ_REMOVE_HEAD)
        begin
            res.removed = list_model.pop_front();
        end
        else if (req == slar_pkg::REQ_REMOVE_TAIL)
        begin
            res.removed = list_model.pop_back();
        end
        else if (pos == 5'd0 || int'(pos) > list_model.size())
        begin
            res.status = slar_pkg::ST_BADPOS;
        end
        else
        begin
            res.removed = list_model[pos - 1];
            list_model.delete(pos - 1);
        end
        res.count = 5'(list_model.size());
        return res;
    endfunction

    function automatic logic signed [31:0] pick_edge_value(input int k);
        case (k)
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4:       return 32'sd1;
            5:       return 32'sh5555_5555;
            6:       return 32'shaaaa_aaaa;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 9) == 0)
            return pick_edge_value($urandom_range(0, 6));
        return $urandom;
    endfunction

    // Offer one word, hold it until taken, then record its predicted result
    task automatic send_request(input slar_pkg::req_t req, input logic signed [31:0] val,
                                input logic [4:0] pos);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        value    <= val;
        position <= pos;
        forever
        begin
            @(negedge clk);
            if (in_ready)
                break;
        end
        @(posedge clk);
        expected_results.push_back(apply_request(req, val, pos));
    endtask

    // Drop the input and wait until every owed result has been taken
    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Take results with random stalls and compare each with the oldest prediction
    initial
    begin : result_sink
        int                 stall;
        logic signed [31:0] got_removed;
        logic [1:0]         got_status;
        logic [4:0]         got_count;
        list_result_t       exp_res;
        @(posedge rst_n);
        forever
        begin
            stall = rx_idle_on ? $urandom_range(0, 19) : 0;
            if (rx_hold_cycles > 0)
            begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            forever
            begin
                @(negedge clk);
                if (out_valid)
                    break;
            end
            got_removed = removed_value;
            got_status  = status;
            got_count   = entry_count;
            @(posedge clk);
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected: removed_value %0d status %0d",
                       got_removed, got_status);
                err_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (got_removed !== exp_res.removed)
                begin
                    $error("removed_value: expected %0d, got %0d", exp_res.removed,
                           got_removed);
                    err_count++;
                end
                if (got_status !== exp_res.status)
                begin
                    $error("status: expected %0d, got %0d", exp_res.status, got_status);
                    err_count++;
                end
                if (got_count !== exp_res.count)
                begin
                    $error("entry_count: expected %0d, got %0d", exp_res.count, got_count);
                    err_count++;
                end
            end
        end
    end

    // Every remove kind on an empty list, position zero among them
    task automatic test_empty_removes();
        send_request(slar_pkg::REQ_REMOVE_HEAD, $urandom, 5'd1);
        send_request(slar_pkg::REQ_REMOVE_TAIL, $urandom, 5'd31);
        send_request(slar_pkg::REQ_REMOVE_POS, $urandom, 5'd0);
    endtask

    // Fill with edge values and random words, then append once more to a full list
    task automatic test_fill_to_full();
        for (int i = 0; i <= slar_pkg::LIST_DEPTH; i++)
            send_request(slar_pkg::REQ_APPEND, pick_edge_value(i), 5'($urandom));
    endtask

    // Out-of-range and in-range positions, head and tail on a full list
    task automatic test_positional_removes();
        send_request(slar_pkg::REQ_REMOVE_POS, $urandom, 5'd0);
        send_request(slar_pkg::REQ_REMOVE_POS, $urandom, 5'd17);
        send_request(slar_pkg::REQ_REMOVE_POS, $urandom, 5'd1);
        send_request(slar_pkg::REQ_REMOVE_POS, $urandom, 5'd15);
        send_request(slar_pkg::REQ_REMOVE_POS, $urandom, 5'd7);
        send_request(slar_pkg::REQ_REMOVE_HEAD, $urandom, 5'd0);
        send_request(slar_pkg::REQ_REMOVE_TAIL, $urandom, 5'd0);
    endtask

    // Random words; append_pct steers the list toward full or toward empty
    task automatic test_random_traffic(input int n_words, input int append_pct);
        slar_pkg::req_t req;
        logic [4:0]     pos;
        int             pick;
        for (int i = 0; i < n_words; i++)
        begin
            if ($urandom_range(0, 99) < append_pct)
            begin
                req = slar_pkg::REQ_APPEND;
            end
            else
            begin
                pick = $urandom_range(0, 3);
                req = (pick == 0) ? slar_pkg::REQ_REMOVE_HEAD :
                      (pick == 1) ? slar_pkg::REQ_REMOVE_TAIL : slar_pkg::REQ_REMOVE_POS;
            end
            // mostly a live position, sometimes any 5-bit value
            if (list_model.size() > 0 && $urandom_range(0, 3) != 0)
                pos = 5'($urandom_range(1, list_model.size()));
            else
                pos = 5'($urandom_range(0, 31));
            send_request(req, pick_value(), pos);
        end
    endtask

    // Hold the output side off while words keep coming so the input stalls
    task automatic test_back_pressure();
        tx_idle_on = 1'b0;
        rx_hold_cycles = 250;
        test_random_traffic(60, 50);
        tx_idle_on = 1'b1;
    endtask

    // Back-to-back words with no idling on either side
    task automatic test_streaming();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_traffic(200, 50);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Bound the run
    initial
    begin : cycle_watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_removes();
        test_fill_to_full();
        test_positional_removes();
        test_random_traffic(300, 75);
        wait_results_done();
        test_random_traffic(300, 25);
        test_back_pressure();
        test_streaming();
        wait_results_done();
        test_random_traffic(300, 50);

        wait_results_done();
        repeat (5) @(posedge clk);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
